[sv/lra_pkg.sv]
// ----------------------------------------------------------------------------
// lra_pkg: shared types and constants of the line rasterizer
// Coordinate widths, request and result payloads, and the command word that
// travels from the front end through the queue to the stepping engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lra_pkg;

  // coordinate width, decision width and queue depth
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned DEC_BITS    = COORD_BITS + 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // request opcode
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // input request payload
  typedef struct packed {
    mode_e                        mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] finish_x;
    logic signed [COORD_BITS-1:0] finish_y;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         valid_res;
    logic                         last;
  } out_res_t;

  // classified command held in the queue
  typedef struct packed {
    mode_e                        mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] finish_x;
    logic signed [COORD_BITS-1:0] finish_y;
    logic                         x_neg;
    logic                         y_neg;
    logic                         steep;
    logic                         single;
    logic [COORD_BITS:0]          two_minor;
    logic [COORD_BITS:0]          two_diff;
    logic [DEC_BITS-1:0]          decision;
  } cmd_t;

endpackage

`default_nettype wire

[sv/line_raster_all_octants_top.sv]
// Path: front-end register, queue slot, then the registered result.
// Throughput: one request per clock, steps and starts alike, while out_ready_i
// does not stall the output; each step is one add and compare on the registered
// decision in the stepping engine.
// A two-entry command queue lets intake continue while a result waits.
// Reset (rst_ni low, asynchronous) empties the pipeline and ends any active line.
// ----------------------------------------------------------------------------
// line_raster_all_octants_top: Bresenham line rasterizer, all eight octants
// Front end sets up each line, a queue decouples it from the stepping engine
// that emits one pixel per start or step request while a line is active.
// ----------------------------------------------------------------------------
`default_nettype none

module line_raster_all_octants_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  lra_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output lra_pkg::out_res_t out_res_o
);
  import lra_pkg::*;

  cmd_t  front_cmd, queue_cmd;
  logic  front_valid, front_ready;
  logic  queue_valid, queue_ready;

  // request intake and line setup
  lra_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // decoupling queue
  lra_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  // stepping engine
  lra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

[sv/lra_front.sv]
// ----------------------------------------------------------------------------
// lra_front: request intake and line setup
// Registers each request with its absolute extents and directions, then
// picks the major axis and the starting decision as the command is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  lra_pkg::in_req_t  in_req_i,
  output logic              cmd_valid_o,
  input  wire               cmd_ready_i,
  output lra_pkg::cmd_t     cmd_o
);
  import lra_pkg::*;

  logic                         valid_q, valid_d;
  in_req_t                      req_q;
  logic [COORD_BITS-1:0]        adx_q, ady_q;
  logic                         xneg_q, yneg_q;

  logic signed [COORD_BITS:0]   dx_s, dy_s;
  logic [COORD_BITS:0]          dx_abs, dy_abs;
  logic                         take;

  logic                         steep;
  logic [COORD_BITS-1:0]        major, minor;
  logic [COORD_BITS-1:0]        diff;

  // intake handshake
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // signed extents and their magnitudes
  always_comb begin
    dx_s   = {in_req_i.finish_x[COORD_BITS-1], in_req_i.finish_x}
           - {in_req_i.start_x[COORD_BITS-1], in_req_i.start_x};
    dy_s   = {in_req_i.finish_y[COORD_BITS-1], in_req_i.finish_y}
           - {in_req_i.start_y[COORD_BITS-1], in_req_i.start_y};
    dx_abs = dx_s[COORD_BITS] ? (~dx_s + 1'b1) : dx_s;
    dy_abs = dy_s[COORD_BITS] ? (~dy_s + 1'b1) : dy_s;
  end

  // stage valid
  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q  <= in_req_i;
      adx_q  <= dx_abs[COORD_BITS-1:0];
      ady_q  <= dy_abs[COORD_BITS-1:0];
      xneg_q <= dx_s[COORD_BITS] || (dx_s == '0);
      yneg_q <= dy_s[COORD_BITS] || (dy_s == '0);
    end
  end

  // axis choice and starting decision
  always_comb begin
    steep = !(adx_q > ady_q);
    major = steep ? ady_q : adx_q;
    minor = steep ? adx_q : ady_q;
    diff  = major - minor;

    cmd_o.mode      = req_q.mode;
    cmd_o.start_x   = req_q.start_x;
    cmd_o.start_y   = req_q.start_y;
    cmd_o.finish_x  = req_q.finish_x;
    cmd_o.finish_y  = req_q.finish_y;
    cmd_o.x_neg     = xneg_q;
    cmd_o.y_neg     = yneg_q;
    cmd_o.steep     = steep;
    cmd_o.single    = (major == '0);
    cmd_o.two_minor = {minor, 1'b0};
    cmd_o.two_diff  = {diff, 1'b0};
    cmd_o.decision  = {3'b000, major} - {2'b00, minor, 1'b0};
  end

  assign cmd_valid_o = valid_q;

endmodule

`default_nettype wire

[sv/lra_queue.sv]
// ----------------------------------------------------------------------------
// lra_queue: command queue between front end and stepping engine
// Small register queue so that intake and pixel output stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_valid_i,
  output logic           push_ready_o,
  input  lra_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  wire            pop_ready_i,
  output lra_pkg::cmd_t  pop_cmd_o
);
  import lra_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  cmd_t                slot_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntBits'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[sv/lra_back.sv]
// ----------------------------------------------------------------------------
// lra_back: stepping engine
// Holds the active line, advances one pixel per step command with the
// Bresenham decision, and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cmd_valid_i,
  output logic              cmd_ready_o,
  input  lra_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output lra_pkg::out_res_t out_res_o
);
  import lra_pkg::*;

  // line state
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] end_x_q, end_x_d, end_y_q, end_y_d;
  logic [COORD_BITS:0]          two_minor_q, two_minor_d, two_diff_q, two_diff_d;
  logic [DEC_BITS-1:0]          decision_q, decision_d;
  logic                         x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic                         steep_q, steep_d, busy_q, busy_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  out_res_t                     res_q, res_d;

  logic                         pop;
  logic                         minor_move;
  logic signed [COORD_BITS-1:0] step_x, step_y, next_x, next_y;
  logic                         fin;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // one Bresenham step from the held state
  always_comb begin
    minor_move = decision_q[DEC_BITS-1] || (decision_q == '0);
    step_x     = x_neg_q ? '1 : COORD_BITS'(1);
    step_y     = y_neg_q ? '1 : COORD_BITS'(1);
    if (steep_q) begin
      next_y = cur_y_q + step_y;
      next_x = minor_move ? cur_x_q + step_x : cur_x_q;
      fin    = (next_y == end_y_q);
    end else begin
      next_x = cur_x_q + step_x;
      next_y = minor_move ? cur_y_q + step_y : cur_y_q;
      fin    = (next_x == end_x_q);
    end
  end

  // command execution
  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    end_x_d     = end_x_q;
    end_y_d     = end_y_q;
    two_minor_d = two_minor_q;
    two_diff_d  = two_diff_q;
    decision_d  = decision_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    steep_d     = steep_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.mode)
        MODE_START: begin
          cur_x_d         = cmd_i.start_x;
          cur_y_d         = cmd_i.start_y;
          end_x_d         = cmd_i.finish_x;
          end_y_d         = cmd_i.finish_y;
          two_minor_d     = cmd_i.two_minor;
          two_diff_d      = cmd_i.two_diff;
          decision_d      = cmd_i.decision;
          x_neg_d         = cmd_i.x_neg;
          y_neg_d         = cmd_i.y_neg;
          steep_d         = cmd_i.steep;
          busy_d          = !cmd_i.single;
          res_d.pixel_x   = cmd_i.start_x;
          res_d.pixel_y   = cmd_i.start_y;
          res_d.valid_res = 1'b1;
          res_d.last      = cmd_i.single;
        end
        MODE_STEP: begin
          if (busy_q) begin
            cur_x_d         = next_x;
            cur_y_d         = next_y;
            decision_d      = minor_move ? decision_q + {2'b00, two_diff_q}
                                         : decision_q - {2'b00, two_minor_q};
            busy_d          = !fin;
            res_d.pixel_x   = next_x;
            res_d.pixel_y   = next_y;
            res_d.valid_res = 1'b1;
            res_d.last      = fin;
          end else begin
            res_d = '0;
          end
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  // control and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      two_minor_q <= '0;
      two_diff_q  <= '0;
      decision_q  <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      steep_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      two_minor_q <= two_minor_d;
      two_diff_q  <= two_diff_d;
      decision_q  <= decision_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      steep_q     <= steep_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire
